FILE: design/thick_line_rasterizer_core_assert.svh
// Assertion macros shared by the thick line rasterizer RTL.
`ifndef THICK_LINE_RASTERIZER_CORE_ASSERT_SVH
`define THICK_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlr assertion failed");

`endif

FILE: design/tlr_pkg.sv
// Package of constants and codes for the thick line rasterizer.
package tlr_pkg;

   // Default geometry
   localparam int COORD_BITS  = 12;
   localparam int MAX_STROKE  = 63;
   localparam int STROKE_BITS = 6;

   // Request kinds carried on tuser
   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // Control register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STROKE_WIDTH = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Control register reset values
   localparam logic [STROKE_BITS-1:0] STROKE_RESET = 6'd1;

endpackage

FILE: design/thick_line_rasterizer_core.sv
// Thick line rasterizer: Bresenham line stamped with a square brush, one pixel per cycle.
//
//   Channel | Direction | Handshake          | Payload
//   req_    | in        | tvalid / tready    | tuser = kind, tdata = endpoints
//   rsp_    | out       | tvalid / tready    | tdata = pixel, tuser = inside, tlast = last
//   csr_    | in        | we (no wait)       | addr = register index, wdata
//
// On each accepted request the state registers update at the accepting edge,
// and an advance places its pixel in the output register at the same edge.
// A new request is accepted every cycle while the output register is empty or
// being drained, so the sustained rate is one pixel per clock.
// Reset is synchronous and active high; it returns the block to idle and loads
// the register defaults (stroke 1, image 2^COORD_BITS square).
// A stalled rsp_ side holds the pixel and backpressures req_ through req_tready.
`include "thick_line_rasterizer_core_assert.svh"

module thick_line_rasterizer_core #(
   parameter int COORD_BITS = tlr_pkg::COORD_BITS,
   parameter int MAX_STROKE = tlr_pkg::MAX_STROKE,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int PIX_BITS      = COORD_BITS + 2,
   localparam int RSP_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8,
   localparam int IMG_BITS      = COORD_BITS + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: x_start, y_start, x_end, y_end (lowest bits first)
   input  logic [REQ_DATA_BITS-1:0]           req_tdata,
   // tuser: req_type
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: pixel_x, pixel_y (lowest bits first), zero padded
   output logic [RSP_DATA_BITS-1:0]           rsp_tdata,
   // tuser: inside_image
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // control registers
   input  logic                               csr_we,
   input  logic [tlr_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [IMG_BITS-1:0]                csr_wdata
);

   localparam int SB       = tlr_pkg::STROKE_BITS;
   // Brush offsets run over -MAX_STROKE/2 .. +MAX_STROKE/2
   localparam int OFS_BITS = $clog2(MAX_STROKE / 2 + 1) + 1;
   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int E2_BITS  = ERR_BITS + 1;
   localparam logic [SB-1:0]       MaxStroke  = SB'(MAX_STROKE);
   localparam logic [IMG_BITS-1:0] ImageReset = IMG_BITS'(1) << COORD_BITS;

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   logic [SB-1:0]       stroke_ff;
   logic [IMG_BITS-1:0] image_w_ff;
   logic [IMG_BITS-1:0] image_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_ff  <= tlr_pkg::STROKE_RESET;
         image_w_ff <= ImageReset;
         image_h_ff <= ImageReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            tlr_pkg::CSR_STROKE_WIDTH: stroke_ff  <= csr_wdata[SB-1:0];
            tlr_pkg::CSR_IMAGE_WIDTH:  image_w_ff <= csr_wdata;
            tlr_pkg::CSR_IMAGE_HEIGHT: image_h_ff <= csr_wdata;
            default: ; // drop writes to unused indexes
         endcase
      end
   end

   // Brush half-size, after clamping the stroke to the supported maximum
   logic [SB-1:0]              stroke_clamped;
   logic signed [OFS_BITS-1:0] half;

   assign stroke_clamped = (stroke_ff > MaxStroke) ? MaxStroke : stroke_ff;
   assign half           = $signed(OFS_BITS'(stroke_clamped >> 1));

   // ---------------------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------------------
   logic [COORD_BITS-1:0]      cur_col_ff,   cur_col_in;
   logic [COORD_BITS-1:0]      cur_row_ff,   cur_row_in;
   logic [COORD_BITS-1:0]      end_col_ff,   end_col_in;
   logic [COORD_BITS-1:0]      end_row_ff,   end_row_in;
   logic [COORD_BITS-1:0]      delta_col_ff, delta_col_in;
   logic [COORD_BITS-1:0]      delta_row_ff, delta_row_in;
   logic                       col_neg_ff,   col_neg_in;
   logic                       row_neg_ff,   row_neg_in;
   logic signed [ERR_BITS-1:0] err_ff,       err_in;
   logic signed [OFS_BITS-1:0] brush_dx_ff,  brush_dx_in;
   logic signed [OFS_BITS-1:0] brush_dy_ff,  brush_dy_in;
   logic                       active_ff,    active_in;

   // Output register contents
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0] rsp_px_ff;
   logic [PIX_BITS-1:0] rsp_py_ff;
   logic                rsp_inside_ff;
   logic                rsp_last_ff;

   // Handshake: the output register parts the two sides
   logic req_acc;
   logic is_start;
   logic emit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign is_start   = (req_tuser == tlr_pkg::REQ_START);
   assign emit       = req_acc && !is_start && active_ff;

   // Endpoint fields
   logic [COORD_BITS-1:0] x0, y0, x1, y1;

   assign x0 = req_tdata[COORD_BITS-1:0];
   assign y0 = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign x1 = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign y1 = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   // Current brush pixel and its flags
   logic signed [PIX_BITS-1:0] px, py;
   logic                       in_image;
   logic                       dx_done, dy_done, at_end, last;

   assign px = $signed({2'b00, cur_col_ff}) + PIX_BITS'(brush_dx_ff);
   assign py = $signed({2'b00, cur_row_ff}) + PIX_BITS'(brush_dy_ff);
   assign in_image = !px[PIX_BITS-1] && !py[PIX_BITS-1]
                     && (px < $signed({1'b0, image_w_ff}))
                     && (py < $signed({1'b0, image_h_ff}));
   // An offset at or past +h ends its loop, so a shrunken stroke still finishes
   assign dx_done = (brush_dx_ff >= half);
   assign dy_done = (brush_dy_ff >= half);
   assign at_end  = (cur_col_ff == end_col_ff) && (cur_row_ff == end_row_ff);
   assign last    = dx_done && dy_done && at_end;

   // Bresenham step terms
   logic signed [ERR_BITS-1:0] dc_s, dr_s;
   logic signed [E2_BITS-1:0]  e2;
   logic                       step_col, step_row;

   assign dc_s     = $signed({2'b00, delta_col_ff});
   assign dr_s     = $signed({2'b00, delta_row_ff});
   assign e2       = E2_BITS'(err_ff) <<< 1;
   assign step_col = e2 > -E2_BITS'(dr_s);
   assign step_row = e2 < E2_BITS'(dc_s);

   always_comb begin
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      end_col_in   = end_col_ff;
      end_row_in   = end_row_ff;
      delta_col_in = delta_col_ff;
      delta_row_in = delta_row_ff;
      col_neg_in   = col_neg_ff;
      row_neg_in   = row_neg_ff;
      err_in       = err_ff;
      brush_dx_in  = brush_dx_ff;
      brush_dy_in  = brush_dy_ff;
      active_in    = active_ff;

      if (req_acc && is_start) begin
         // Load a new line, dropping any line in progress
         cur_col_in   = x0;
         cur_row_in   = y0;
         end_col_in   = x1;
         end_row_in   = y1;
         delta_col_in = (x1 > x0) ? (x1 - x0) : (x0 - x1);
         delta_row_in = (y1 > y0) ? (y1 - y0) : (y0 - y1);
         col_neg_in   = !(x0 < x1);
         row_neg_in   = !(y0 < y1);
         err_in       = $signed({2'b00, delta_col_in}) - $signed({2'b00, delta_row_in});
         brush_dx_in  = -half;
         brush_dy_in  = -half;
         active_in    = 1'b1;
      end else if (emit) begin
         if (dy_done) begin
            brush_dy_in = -half;
            if (dx_done) begin
               brush_dx_in = -half;
               if (at_end) begin
                  active_in = 1'b0;
               end else begin
                  // Both tests use the error before this step
                  err_in = err_ff - (step_col ? dr_s : '0) + (step_row ? dc_s : '0);
                  if (step_col) begin
                     cur_col_in = col_neg_ff ? cur_col_ff - 1'b1 : cur_col_ff + 1'b1;
                  end
                  if (step_row) begin
                     cur_row_in = row_neg_ff ? cur_row_ff - 1'b1 : cur_row_ff + 1'b1;
                  end
               end
            end else begin
               brush_dx_in = brush_dx_ff + 1'b1;
            end
         end else begin
            brush_dy_in = brush_dy_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         end_col_ff   <= '0;
         end_row_ff   <= '0;
         delta_col_ff <= '0;
         delta_row_ff <= '0;
         col_neg_ff   <= 1'b0;
         row_neg_ff   <= 1'b0;
         err_ff       <= '0;
         brush_dx_ff  <= '0;
         brush_dy_ff  <= '0;
         active_ff    <= 1'b0;
      end else begin
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         end_col_ff   <= end_col_in;
         end_row_ff   <= end_row_in;
         delta_col_ff <= delta_col_in;
         delta_row_ff <= delta_row_in;
         col_neg_ff   <= col_neg_in;
         row_neg_ff   <= row_neg_in;
         err_ff       <= err_in;
         brush_dx_ff  <= brush_dx_in;
         brush_dy_ff  <= brush_dy_in;
         active_ff    <= active_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   // Load on emit, clear once the transaction completes, otherwise hold
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_px_ff     <= px;
         rsp_py_ff     <= py;
         rsp_inside_ff <= in_image;
         rsp_last_ff   <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_py_ff, rsp_px_ff});
   assign rsp_tuser  = rsp_inside_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `TLR_ASSERT_NEXT(a_last_goes_idle, clock, reset, emit && last, !active_ff)
   `TLR_ASSERT_NEXT(a_emit_shows_pixel, clock, reset, emit, rsp_tvalid && rsp_tlast == $past(last))
   `TLR_ASSERT_NEXT(a_idle_advance_silent, clock, reset,
                    req_acc && !is_start && !active_ff, !rsp_tvalid)
   `TLR_ASSERT_NEXT(a_start_loads_brush, clock, reset, req_acc && is_start,
                    active_ff && brush_dx_ff == -$past(half) && brush_dy_ff == -$past(half))

endmodule

FILE: tb/tb_thick_line_rasterizer_core.sv
// Self-checking testbench for the thick line rasterizer core.
`timescale 1ns / 1ps

module tb_thick_line_rasterizer_core;

   // Run limit in clock cycles; the slowest legal run stays far below it.
   localparam int CYCLE_LIMIT  = 600000;
   // Cycles to let pass after the last expected pixel, as a settling margin.
   localparam int SETTLE_CYCLES = 4;
   // Requests per random run: 3 idle modes x 4 settings x 100, plus the
   // directed tests, come to about 1650.
   localparam int PHASE_QUOTA  = 100;

   // One expected pixel as it leaves the core.
   typedef struct {
      logic [13:0] col;
      logic [13:0] row;
      logic        in_image;
      logic        last;
   } pixel_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // tdata: x_start, y_start, x_end, y_end (lowest bits first)
   logic [47:0] req_tdata   = '0;
   // tuser: req_type
   logic        req_tuser   = tlr_pkg::REQ_START;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // tdata: pixel_x, pixel_y (lowest bits first), zero padded
   logic [31:0] rsp_tdata;
   // tuser: inside_image
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_addr    = tlr_pkg::CSR_STROKE_WIDTH;
   logic [12:0] csr_wdata   = '0;

   // Expected pixels, oldest first.
   pixel_type pixel_q[$];

   // Shadow copy of the control registers.
   int stroke_cfg = 1;
   int width_cfg  = 4096;
   int height_cfg = 4096;

   // Shadow copy of the line walker.
   int col_pos, row_pos, col_end, row_end;
   int col_span, row_span, err_acc, off_x, off_y;
   bit col_dec, row_dec;
   bit line_active;

   // Idle rates in percent for the request and result sides.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int err_count      = 0;
   int cycle_count    = 0;
   int requests_sent  = 0;
   int lines_started  = 0;
   int pixels_checked = 0;
   int inside_seen    = 0;
   int ends_seen      = 0;

   thick_line_rasterizer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_thick_line_rasterizer_core failed");
         $finish;
      end
   end

   // Result side backpressure: drop tready at random at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Walk the line one request at a time and queue the pixel it produces.
   // A start loads the endpoints and emits nothing; an advance on an active
   // line emits the current brush pixel and then steps the brush, and the line
   // point once the brush of that point is complete.
   task automatic rasterize_request(input logic kind, input logic [47:0] data);
      int half = stroke_cfg / 2;
      int x0 = data[11:0];
      int y0 = data[23:12];
      int x1 = data[35:24];
      int y1 = data[47:36];
      int px, py, e2;
      bit at_end;
      pixel_type pix;
      if (kind == tlr_pkg::REQ_START) begin
         col_pos     = x0;
         row_pos     = y0;
         col_end     = x1;
         row_end     = y1;
         col_span    = (x1 > x0) ? x1 - x0 : x0 - x1;
         row_span    = (y1 > y0) ? y1 - y0 : y0 - y1;
         col_dec     = !(x0 < x1);
         row_dec     = !(y0 < y1);
         err_acc     = col_span - row_span;
         off_x       = -half;
         off_y       = -half;
         line_active = 1'b1;
         lines_started++;
      end else if (line_active) begin
         px = col_pos + off_x;
         py = row_pos + off_y;
         at_end = (col_pos == col_end) && (row_pos == row_end);
         pix.col      = px[13:0];
         pix.row      = py[13:0];
         pix.in_image = (px >= 0) && (py >= 0) && (px < width_cfg) && (py < height_cfg);
         pix.last     = (off_x >= half) && (off_y >= half) && at_end;
         pixel_q.push_back(pix);
         // An offset at or past +half closes its loop, even after a stroke change.
         if (off_y >= half) begin
            off_y = -half;
            if (off_x >= half) begin
               off_x = -half;
               if (at_end) begin
                  line_active = 1'b0;
               end else begin
                  e2 = 2 * err_acc;
                  if (e2 > -row_span) begin
                     err_acc -= row_span;
                     col_pos += col_dec ? -1 : 1;
                  end
                  if (e2 < col_span) begin
                     err_acc += col_span;
                     row_pos += row_dec ? -1 : 1;
                  end
               end
            end else begin
               off_x++;
            end
         end else begin
            off_y++;
         end
      end
   endtask

   // Check each accepted result against the oldest expected pixel.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d", $signed(rsp_tdata[13:0]),
                   $signed(rsp_tdata[27:14]));
            err_count++;
         end else begin
            want = pixel_q.pop_front();
            pixels_checked++;
            if (rsp_tuser) inside_seen++;
            if (rsp_tlast) ends_seen++;
            if (rsp_tdata[13:0] !== want.col) begin
               $error("pixel_x: expected %0d, got %0d", $signed(want.col),
                      $signed(rsp_tdata[13:0]));
               err_count++;
            end
            if (rsp_tdata[27:14] !== want.row) begin
               $error("pixel_y: expected %0d, got %0d", $signed(want.row),
                      $signed(rsp_tdata[27:14]));
               err_count++;
            end
            if (rsp_tuser !== want.in_image) begin
               $error("inside_image: expected %0d, got %0d", want.in_image, rsp_tuser);
               err_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   // Present one request and hold it until accepted. Enter and leave at a falling edge;
   // tvalid stays high on return so back-to-back requests need no extra assignment.
   task automatic push_request(input logic kind, input logic [47:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      rasterize_request(kind, data);
      requests_sent++;
      @(negedge clock);
   endtask

   // Advance with random payload on the unused endpoint bits.
   task automatic push_advance();
      logic [47:0] junk;
      junk[31:0]  = $urandom;
      junk[47:32] = 16'($urandom_range(16'hFFFF));
      push_request(tlr_pkg::REQ_ADVANCE, junk);
   endtask

   task automatic push_line(input int xs, input int ys, input int xe, input int ye);
      logic [11:0] a = 12'(xs), b = 12'(ys), c = 12'(xe), d = 12'(ye);
      push_request(tlr_pkg::REQ_START, {d, c, b, a});
   endtask

   // Hold off the sender until every expected pixel has come, then settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all three registers back to back; only done with the core drained.
   task automatic configure(input int stroke, input int img_w, input int img_h);
      wait_drain();
      csr_we    <= 1'b1;
      csr_addr  <= tlr_pkg::CSR_STROKE_WIDTH;
      csr_wdata <= 13'(stroke);
      @(negedge clock);
      csr_addr  <= tlr_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= 13'(img_w);
      @(negedge clock);
      csr_addr  <= tlr_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= 13'(img_h);
      @(negedge clock);
      csr_we    <= 1'b0;
      stroke_cfg = stroke & 6'h3F;
      width_cfg  = img_w & 13'h1FFF;
      height_cfg = img_h & 13'h1FFF;
   endtask

   task automatic finish_line();
      while (line_active) push_advance();
   endtask

   // Coordinate biased toward the image border and the coordinate extremes.
   function automatic int pick_coord(input int limit);
      int v;
      case ($urandom_range(3))
         0: v = $urandom_range(4095);
         1: v = $urandom_range(8);
         2: v = $urandom_range(4095, 4087);
         default: v = limit - 4 + $urandom_range(8);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   function automatic int near_coord(input int base, input int span);
      int v = base + $urandom_range(2 * span) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   // Advance on an idle core: nothing may come out.
   task automatic test_idle_advance();
      push_advance();
      wait_drain();
   endtask

   // Single-point line with the reset stroke: one pixel, flagged last, then idle again.
   task automatic test_single_point();
      push_line(0, 0, 0, 0);
      push_advance();
      push_advance();
      wait_drain();
   endtask

   // Lines at the far corners of the coordinate range, diagonal and shallow.
   task automatic test_coord_extremes();
      push_line(4095, 0, 4093, 2);
      finish_line();
      push_line(0, 4095, 2, 4094);
      finish_line();
      wait_drain();
   endtask

   // Restart while a long line is still being drawn.
   task automatic test_restart();
      push_line(0, 0, 4095, 4095);
      push_advance();
      push_advance();
      push_line(4095, 4095, 4095, 4095);
      finish_line();
      wait_drain();
   endtask

   // Zero-sized image: every pixel is outside.
   task automatic test_zero_image();
      configure(2, 0, 0);
      push_line(0, 0, 1, 0);
      push_advance();
      push_advance();
      push_advance();
      configure(1, 4096, 4096);
   endtask

   // Full-size brush on corner points, shrunk partway through the brush.
   task automatic test_stroke_change();
      configure(63, 4096, 4096);
      push_line(0, 4095, 0, 4095);
      repeat (100) push_advance();
      configure(2, 4096, 4096);
      finish_line();
      configure(63, 4096, 4096);
      push_line(4095, 0, 4094, 1);
      repeat (100) push_advance();
      configure(2, 4096, 4096);
      finish_line();
      configure(1, 4096, 4096);
   endtask

   // Mostly complete short lines with random endpoints; some long or cut-off
   // lines, and stray advances on an idle core as noise.
   task automatic run_random_lines(input int quota);
      int done_items = 0;
      int xs, ys, xe, ye, budget;
      bit broken;
      while (done_items < quota) begin
         xs = pick_coord(width_cfg);
         ys = pick_coord(height_cfg);
         if ($urandom_range(9) == 0) begin
            xe = $urandom_range(4095);
            ye = $urandom_range(4095);
            broken = 1'b1;
         end else begin
            xe = near_coord(xs, $urandom_range(5));
            ye = near_coord(ys, $urandom_range(5));
            broken = ($urandom_range(7) == 0);
         end
         budget = broken ? $urandom_range(40) : quota;
         push_line(xs, ys, xe, ye);
         done_items++;
         while (line_active && budget > 0 && done_items < quota) begin
            push_advance();
            done_items++;
            budget--;
         end
         if (!line_active && $urandom_range(5) == 0) begin
            repeat ($urandom_range(2, 1)) push_advance();
         end
         // Occasionally let the core drain completely before going on.
         if ($urandom_range(49) == 0) wait_drain();
      end
   endtask

   // Random phases under one idle mode, over several register settings.
   task automatic test_random_phase(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      configure(0, 4096, 4096);
      run_random_lines(PHASE_QUOTA);
      configure($urandom_range(7, 1), $urandom_range(16, 1), $urandom_range(16, 1));
      run_random_lines(PHASE_QUOTA);
      configure($urandom_range(9, 2), $urandom_range(4096, 1), $urandom_range(4096, 1));
      run_random_lines(PHASE_QUOTA);
      configure($urandom_range(5, 1), 4096, 1);
      run_random_lines(PHASE_QUOTA);
   endtask

   initial begin
      // Hold reset from the start, released at a falling edge.
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 55;
      test_idle_advance();
      test_single_point();
      test_coord_extremes();
      test_restart();
      test_zero_image();
      test_stroke_change();

      test_random_phase(11, 55);
      test_random_phase(55, 11);
      test_random_phase(0, 0);

      // Drain what is left and give the core time to show any stray pixel.
      wait_drain();
      repeat (10) @(negedge clock);

      $display("Run covered %0d requests over %0d lines; %0d pixels checked.",
               requests_sent, lines_started, pixels_checked);
      $display("Of those, %0d inside the image and %0d line ends; strokes 0..63.",
               inside_seen, ends_seen);
      if (err_count == 0 && pixel_q.size() == 0) begin
         $display("tb_thick_line_rasterizer_core passed");
      end else begin
         $display("tb_thick_line_rasterizer_core failed");
      end
      $finish;
   end

endmodule
